// ===== src/sorted_list_queue_top_defines.svh =====
// ---------------------------------------------------------------------------
// Sorted list queue assertion macros
// Shared property wrappers for the checker of the sorted list queue.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_QUEUE_TOP_DEFINES_SVH
`define SORTED_LIST_QUEUE_TOP_DEFINES_SVH

// A property that is checked only outside of reset.
`define SLQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property that is also checked while reset is applied.
`define SLQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/slq_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted list queue package
// Shared widths, action and status codes, and the cell control bundle.
// ---------------------------------------------------------------------------
package slq_pkg;

  localparam int DATA_W       = 32;
  localparam int ACTION_W     = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 5;
  localparam int CAPACITY_DEF = 16;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POPF   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POPB   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DUMP   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_APPEND = 2'd2,
    CELL_POPF   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

// ===== src/slq_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted list queue cell
// Holds one list entry and shifts it toward either neighbor on command.
// ---------------------------------------------------------------------------
module slq_cell #(
  parameter int INDEX   = 0,
  parameter int COUNT_W = 5
) (
  input  logic                              clk,
  input  slq_pkg::cell_ctrl_t               ctrl,
  input  logic [COUNT_W-1:0]                count,
  input  logic signed [slq_pkg::DATA_W-1:0] left_entry,
  input  logic signed [slq_pkg::DATA_W-1:0] right_entry,
  input  logic                              still_in,
  output logic                              still_out,
  output logic signed [slq_pkg::DATA_W-1:0] entry
);
  import slq_pkg::*;

  logic occupied;
  logic less;

  assign occupied  = COUNT_W'(INDEX) < count;
  assign less      = occupied && (entry < ctrl.value);
  assign still_out = still_in && less;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (!still_in) begin
          entry <= left_entry;
        end else if (!less) begin
          entry <= ctrl.value;
        end
      end
      CELL_APPEND: begin
        if (COUNT_W'(INDEX) == count) begin
          entry <= ctrl.value;
        end
      end
      CELL_POPF: begin
        entry <= right_entry;
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

// ===== src/sorted_list_queue_top.sv =====
// ---------------------------------------------------------------------------
// Sorted list queue top level
// A bounded ordered list of signed values built as a row of entry cells.
// ---------------------------------------------------------------------------
// Each input transfer carries an action and a value. Sorted insert, append,
// pop front and pop back change the list in the cycle of the transfer: on
// insert every cell compares against the new value and shifts toward its
// neighbor at once. Each of these produces one result, registered so that
// it appears in the cycle after the input transfer, so such items go through
// at one per cycle while the output is not stalled. A dump of n entries
// produces n results, one per free output cycle, the last one marked; the
// input stalls until the final dump result is loaded, since the entries are
// read out one per cycle through a single read mux. Inserts or appends into
// a full list and pops or dumps of an empty list give one result with a full
// or empty status and leave the list as is. The output register holds its
// result while out_stall is high, and the input is stalled only while that
// register is occupied and stalled or a dump is in progress. Reset empties
// the list and drops any pending result; the stored entries are not cleared.
module sorted_list_queue_top #(
  parameter int CAPACITY = slq_pkg::CAPACITY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [slq_pkg::ACTION_W-1:0]           action,
  input  logic signed [slq_pkg::DATA_W-1:0]      value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [slq_pkg::DATA_W-1:0]      value_out,
  output logic [slq_pkg::STATUS_W-1:0]           status,
  output logic [slq_pkg::COUNT_OUT_W-1:0]        entry_count,
  output logic                                   last
);
  import slq_pkg::*;

  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W   = $clog2(CAPACITY);

  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic                     still [CAPACITY+1];
  logic signed [DATA_W-1:0] left_in [CAPACITY];
  logic signed [DATA_W-1:0] right_in [CAPACITY];

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               dumping;
  logic               dumping_next;
  logic [IDX_W-1:0]   dump_idx;
  logic [IDX_W-1:0]   dump_idx_next;
  logic [IDX_W-1:0]   tail_idx;

  logic                     accept;
  logic                     out_load;
  logic                     res_load;
  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] res_value;
  logic [STATUS_W-1:0]      res_status;
  logic                     res_last;
  logic                     is_full;
  logic                     is_empty;

  assign out_load = !out_valid || !out_stall;
  assign in_stall = dumping || !out_load;
  assign accept   = in_valid && !in_stall;
  assign is_full  = count == COUNT_W'(CAPACITY);
  assign is_empty = count == '0;
  assign tail_idx = IDX_W'(count - 1'b1);
  assign still[0] = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_in[i] = ctrl.value;
    end else begin : g_body
      assign left_in[i] = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_in[i] = '0;
    end else begin : g_inner
      assign right_in[i] = entries[i+1];
    end

    slq_cell #(
      .INDEX   (i),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .left_entry  (left_in[i]),
      .right_entry (right_in[i]),
      .still_in    (still[i]),
      .still_out   (still[i+1]),
      .entry       (entries[i])
    );
  end

  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.value    = value;
    count_next    = count;
    dumping_next  = dumping;
    dump_idx_next = dump_idx;
    res_load      = 1'b0;
    res_value     = '0;
    res_status    = ST_OK;
    res_last      = 1'b1;
    if (dumping) begin
      if (out_load) begin
        res_load      = 1'b1;
        res_value     = entries[dump_idx];
        res_last      = dump_idx == tail_idx;
        dump_idx_next = IDX_W'(dump_idx + 1'b1);
        dumping_next  = dump_idx != tail_idx;
      end
    end else if (accept) begin
      res_load = 1'b1;
      case (action)
        ACT_INSERT, ACT_APPEND: begin
          if (is_full) begin
            res_status = ST_FULL;
          end else begin
            ctrl.op    = (action == ACT_INSERT) ? CELL_INSERT : CELL_APPEND;
            count_next = COUNT_W'(count + 1'b1);
          end
        end
        ACT_POPF: begin
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else begin
            ctrl.op    = CELL_POPF;
            res_value  = entries[0];
            count_next = COUNT_W'(count - 1'b1);
          end
        end
        ACT_POPB: begin
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_value  = entries[tail_idx];
            count_next = COUNT_W'(count - 1'b1);
          end
        end
        ACT_DUMP: begin
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_value     = entries[0];
            res_last      = count == COUNT_W'(1);
            dumping_next  = count != COUNT_W'(1);
            dump_idx_next = IDX_W'(1);
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dumping   <= 1'b0;
      dump_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      count    <= count_next;
      dumping  <= dumping_next;
      dump_idx <= dump_idx_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      value_out   <= res_value;
      status      <= res_status;
      entry_count <= COUNT_OUT_W'(count_next);
      last        <= res_last;
    end
  end

endmodule

// ===== src/slq_checker.sv =====
// ---------------------------------------------------------------------------
// Sorted list queue checker
// Port-level properties of the sorted list queue, bound to the top level.
// ---------------------------------------------------------------------------
`include "sorted_list_queue_top_defines.svh"

module slq_checker #(
  parameter int CAPACITY = slq_pkg::CAPACITY_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [slq_pkg::ACTION_W-1:0]      action,
  input logic signed [slq_pkg::DATA_W-1:0] value,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [slq_pkg::DATA_W-1:0] value_out,
  input logic [slq_pkg::STATUS_W-1:0]      status,
  input logic [slq_pkg::COUNT_OUT_W-1:0]   entry_count,
  input logic                              last
);
  import slq_pkg::*;

  `SLQ_ASSERT_RST(a_reset_clears_output, rst |=> !out_valid, "result pending after reset")

  `SLQ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(status) && $stable(entry_count) && $stable(last), "stalled result changed")

  `SLQ_ASSERT(a_status_code, out_valid |-> status == ST_OK || status == ST_EMPTY || status == ST_FULL, "undefined status code")

  `SLQ_ASSERT(a_error_result, out_valid && (status == ST_EMPTY || status == ST_FULL) |-> last && value_out == '0, "error result not final or carries a value")

  `SLQ_ASSERT(a_count_bound, out_valid |-> CAPACITY > 31 || entry_count <= COUNT_OUT_W'(CAPACITY), "entry count beyond capacity")

endmodule

bind sorted_list_queue_top slq_checker #(
  .CAPACITY (CAPACITY)
) u_slq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .action      (action),
  .value       (value),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .value_out   (value_out),
  .status      (status),
  .entry_count (entry_count),
  .last        (last)
);

// ===== test/slq_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sorted list queue checker
// Watches both channels of the sorted list queue, keeps its own copy of the
// list, predicts every result of each accepted request and compares them in
// order, field by field.
// ---------------------------------------------------------------------------
module slq_scoreboard #(
  parameter int CAPACITY = slq_pkg::CAPACITY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic [slq_pkg::ACTION_W-1:0]           action,
  input  logic signed [slq_pkg::DATA_W-1:0]      value,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic signed [slq_pkg::DATA_W-1:0]      value_out,
  input  logic [slq_pkg::STATUS_W-1:0]           status,
  input  logic [slq_pkg::COUNT_OUT_W-1:0]        entry_count,
  input  logic                                   last,
  output int                                     error_count,
  output int                                     pending,
  output int                                     checked
);
  import slq_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     last;
  } outcome_t;

  logic signed [DATA_W-1:0] list_vals [CAPACITY];
  int                       list_len;
  outcome_t                 expected_q[$];

  task automatic push_outcome(input logic signed [DATA_W-1:0] val,
                              input logic [STATUS_W-1:0] st, input logic fin);
    outcome_t item;
    item.value  = val;
    item.status = st;
    item.count  = list_len[COUNT_OUT_W-1:0];
    item.last   = fin;
    expected_q.push_back(item);
  endtask

  task automatic predict_request(input logic [ACTION_W-1:0] act,
                                 input logic signed [DATA_W-1:0] val);
    int                       pos;
    logic signed [DATA_W-1:0] head;
    case (act)
      ACT_INSERT, ACT_APPEND: begin
        if (list_len >= CAPACITY) begin
          push_outcome('0, ST_FULL, 1'b1);
        end else begin
          pos = list_len;
          if (act == ACT_INSERT) begin
            pos = 0;
            while (pos < list_len && list_vals[pos] < val) pos++;
          end
          for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = val;
          list_len++;
          push_outcome('0, ST_OK, 1'b1);
        end
      end
      ACT_POPF: begin
        if (list_len == 0) begin
          push_outcome('0, ST_EMPTY, 1'b1);
        end else begin
          head = list_vals[0];
          for (int i = 1; i < list_len; i++) list_vals[i-1] = list_vals[i];
          list_len--;
          push_outcome(head, ST_OK, 1'b1);
        end
      end
      ACT_POPB: begin
        if (list_len == 0) begin
          push_outcome('0, ST_EMPTY, 1'b1);
        end else begin
          list_len--;
          push_outcome(list_vals[list_len], ST_OK, 1'b1);
        end
      end
      ACT_DUMP: begin
        if (list_len == 0) begin
          push_outcome('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            push_outcome(list_vals[i], ST_OK, i == list_len - 1);
          end
        end
      end
      default: push_outcome('0, ST_OK, 1'b1);
    endcase
  endtask

  task automatic check_field(input string name, input logic signed [DATA_W:0] want,
                             input logic signed [DATA_W:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      list_len = 0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_request(action, value);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected, expected none, actual value_out %0d",
                   $time, value_out);
        end else begin
          want = expected_q.pop_front();
          check_field("value_out", want.value, value_out);
          check_field("status", want.status, status);
          check_field("entry_count", want.count, entry_count);
          check_field("last", want.last, last);
          checked++;
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sorted list queue testbench
// Drives directed corner requests and then random fill, drain and mixed
// bursts into the sorted list queue, with random idle cycles on both sides,
// while the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
  import slq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 100;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [ACTION_W-1:0]        action = '0;
  logic signed [DATA_W-1:0]   value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [DATA_W-1:0]   value_out;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_OUT_W-1:0]     entry_count;
  logic                       last;

  int error_count;
  int pending;
  int checked;
  int sent = 0;
  int cycles = 0;
  logic calm = 1'b0;

  always #6 clk = ~clk;

  sorted_list_queue_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .value_out(value_out),
    .status(status), .entry_count(entry_count), .last(last)
  );

  slq_scoreboard checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .value_out(value_out),
    .status(status), .entry_count(entry_count), .last(last),
    .error_count(error_count), .pending(pending), .checked(checked)
  );

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic put_item(input logic [ACTION_W-1:0] act,
                          input logic signed [DATA_W-1:0] val);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act <= ACT_DUMP) sent++;
  endtask

  initial begin
    int burst;
    int len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    put_item(ACT_POPF, 32'sh7fffffff);
    put_item(ACT_POPB, 32'sh80000000);
    put_item(ACT_DUMP, -1);
    for (int c = ACT_DUMP + 1; c < (1 << ACTION_W); c++) put_item(ACTION_W'(c), $urandom);
    put_item(ACT_INSERT, 0);
    put_item(ACT_INSERT, 32'sh7fffffff);
    put_item(ACT_INSERT, 32'sh80000000);
    put_item(ACT_INSERT, 0);
    put_item(ACT_INSERT, -1);
    put_item(ACT_APPEND, 32'sh80000000);
    put_item(ACT_APPEND, 32'sh7fffffff);
    put_item(ACT_DUMP, 0);
    put_item(ACT_POPF, 0);
    put_item(ACT_POPB, 0);
    put_item(ACT_POPB, 0);
    put_item(ACT_POPF, 0);
    put_item(ACT_DUMP, 0);
    put_item(ACT_POPF, 0);
    put_item(ACT_POPF, 0);
    put_item(ACT_POPB, 0);
    put_item(ACT_DUMP, 0);

    sent = 0;
    burst = 0;
    while (sent < RANDOM_ITEMS) begin
      calm <= (burst >= 4 && burst < 7);
      case ($urandom_range(3))
        0: begin
          len = $urandom_range(20, 12);
          for (int i = 0; i < len; i++) begin
            put_item($urandom_range(3) == 0 ? ACT_APPEND : ACT_INSERT, pick_value());
          end
          put_item(ACT_DUMP, $urandom);
        end
        1: begin
          len = $urandom_range(20, 4);
          for (int i = 0; i < len; i++) begin
            put_item($urandom_range(1) ? ACT_POPF : ACT_POPB, $urandom);
          end
          put_item(ACT_DUMP, $urandom);
        end
        default: begin
          len = $urandom_range(15, 5);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) begin
              put_item(ACTION_W'($urandom_range((1 << ACTION_W) - 1, ACT_DUMP + 1)),
                       $urandom);
            end else begin
              put_item(ACTION_W'($urandom_range(ACT_DUMP)), pick_value());
            end
          end
        end
      endcase
      burst++;
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("Random part: %0d requests in %0d bursts of filling, draining and mixing.",
             sent, burst);
    $display("Results compared: %0d, with errors found: %0d.", checked, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
